FILE: rtl/ihdp_pkg.sv
package ihdp_pkg;

  // one byte of the file stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } feed_t;

  // one answer per file
  typedef struct packed {
    logic        status;
    logic [30:0] width;
    logic [30:0] height;
  } result_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_PNG,
    PH_JFF,
    PH_JCODE,
    PH_LENHI,
    PH_LENLO,
    PH_SKIP,
    PH_SOF
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  byte_position;
    logic [7:0]  current_marker;
    logic [15:0] segment_count;
    logic [31:0] width_accum;
    logic [31:0] height_accum;
    logic        answered;
    logic        header_match;
  } probe_state_t;

  localparam probe_state_t STATE_RESET = '{
    phase:          PH_START,
    byte_position:  5'd0,
    current_marker: 8'h00,
    segment_count:  16'h0000,
    width_accum:    32'h0,
    height_accum:   32'h0,
    answered:       1'b0,
    header_match:   1'b1
  };

  // jpeg marker codes
  localparam logic [7:0] MK_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_TEM  = 8'h01;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_SOFF = 8'hCF;
  localparam logic [7:0] MK_DHT  = 8'hC4;
  localparam logic [7:0] MK_JPG  = 8'hC8;
  localparam logic [7:0] MK_DAC  = 8'hCC;

  // png header characters
  localparam logic [7:0] PNG_SIG0 = 8'h89;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_R = 8'h52;

  localparam logic [4:0] PNG_LAST_POS = 5'd23;

  function automatic logic is_sof(input logic [7:0] m);
    is_sof = (m >= MK_SOF0) && (m <= MK_SOFF) &&
             (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

endpackage

FILE: rtl/ihdp_step.sv
module ihdp_step (
  input  ihdp_pkg::probe_state_t cur,
  input  ihdp_pkg::feed_t        item,
  output ihdp_pkg::probe_state_t nxt,
  output logic                   emit,
  output ihdp_pkg::result_t      res
);
  import ihdp_pkg::*;

  logic [7:0]  b;
  logic [4:0]  p;
  logic [15:0] seg;
  logic        emit_ok;

  // dimensions come from the updated accumulators before an end-of-file clear
  logic [31:0] w_upd;
  logic [31:0] h_upd;

  assign b = item.data_byte;
  assign p = cur.byte_position;

  always_comb begin
    nxt     = cur;
    emit    = 1'b0;
    emit_ok = 1'b0;
    seg     = cur.segment_count | {8'h00, b};
    if (!cur.answered) begin
      unique case (cur.phase)
        PH_START: begin
          if (p == 5'd0) begin
            nxt.current_marker = b;
            nxt.header_match   = (b == PNG_SIG0);
            nxt.byte_position  = 5'd1;
          end else if (cur.current_marker == MK_FILL && b == MK_SOI) begin
            nxt.phase = PH_JFF;
          end else begin
            nxt.header_match  = cur.header_match && (b == CH_P);
            nxt.byte_position = 5'd2;
            nxt.phase         = PH_PNG;
          end
        end
        PH_PNG: begin
          priority if (p == 5'd2)  nxt.header_match = cur.header_match && (b == CH_N);
          else if (p == 5'd3)      nxt.header_match = cur.header_match && (b == CH_G);
          else if (p == 5'd12)     nxt.header_match = cur.header_match && (b == CH_I);
          else if (p == 5'd13)     nxt.header_match = cur.header_match && (b == CH_H);
          else if (p == 5'd14)     nxt.header_match = cur.header_match && (b == CH_D);
          else if (p == 5'd15)     nxt.header_match = cur.header_match && (b == CH_R);
          else if (p >= 5'd16 && p <= 5'd19)
            nxt.width_accum = {cur.width_accum[23:0], b};
          else if (p >= 5'd20 && p <= 5'd23)
            nxt.height_accum = {cur.height_accum[23:0], b};
          else begin
          end
          if (p >= PNG_LAST_POS) begin
            emit    = 1'b1;
            emit_ok = nxt.header_match &&
                      (nxt.width_accum != 32'h0) && !nxt.width_accum[31] &&
                      (nxt.height_accum != 32'h0) && !nxt.height_accum[31];
          end else begin
            nxt.byte_position = p + 5'd1;
          end
        end
        PH_JFF: begin
          if (b != MK_FILL) emit = 1'b1;
          else nxt.phase = PH_JCODE;
        end
        PH_JCODE: begin
          priority if (b == MK_FILL) begin
          end else if (b == MK_SOI || b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7)) begin
            nxt.phase = PH_JFF;
          end else if (b == MK_EOI || b == MK_SOS) begin
            emit = 1'b1;
          end else begin
            nxt.current_marker = b;
            nxt.phase          = PH_LENHI;
          end
        end
        PH_LENHI: begin
          nxt.segment_count = {b, 8'h00};
          nxt.phase         = PH_LENLO;
        end
        PH_LENLO: begin
          nxt.segment_count = seg;
          priority if (seg < 16'd2) begin
            emit = 1'b1;
          end else if (is_sof(cur.current_marker)) begin
            if (seg < 16'd7) begin
              emit = 1'b1;
            end else begin
              nxt.byte_position = 5'd0;
              nxt.phase         = PH_SOF;
            end
          end else begin
            nxt.segment_count = seg - 16'd2;
            nxt.phase         = (seg == 16'd2) ? PH_JFF : PH_SKIP;
          end
        end
        PH_SKIP: begin
          nxt.segment_count = cur.segment_count - 16'd1;
          if (cur.segment_count == 16'd1) nxt.phase = PH_JFF;
        end
        PH_SOF: begin
          // precision byte first, then height and width, big-endian
          if (p == 5'd1 || p == 5'd2)
            nxt.height_accum = {16'h0000, cur.height_accum[7:0], b};
          else if (p >= 5'd3)
            nxt.width_accum = {16'h0000, cur.width_accum[7:0], b};
          if (p >= 5'd4) begin
            emit    = 1'b1;
            emit_ok = (nxt.width_accum != 32'h0) && (nxt.height_accum != 32'h0);
          end else begin
            nxt.byte_position = p + 5'd1;
          end
        end
      endcase
    end
    if (emit) nxt.answered = 1'b1;
    // end of file: answer bad if still open, then back to start of file
    if (item.end_of_file) begin
      if (!nxt.answered) begin
        emit    = 1'b1;
        emit_ok = 1'b0;
      end
      nxt = STATE_RESET;
    end
  end

  always_comb begin
    w_upd = cur.width_accum;
    h_upd = cur.height_accum;
    if (cur.phase == PH_PNG) begin
      if (p >= 5'd16 && p <= 5'd19) w_upd = {cur.width_accum[23:0], b};
      if (p >= 5'd20 && p <= 5'd23) h_upd = {cur.height_accum[23:0], b};
    end else if (cur.phase == PH_SOF) begin
      if (p >= 5'd3) w_upd = {16'h0000, cur.width_accum[7:0], b};
    end
  end

  always_comb begin
    res.status = !emit_ok;
    res.width  = emit_ok ? w_upd[30:0] : 31'd0;
    res.height = emit_ok ? h_upd[30:0] : 31'd0;
  end

endmodule

FILE: rtl/image_header_dimension_probe_core.sv
// image header dimension probe
//
// feed channel: one file byte per transfer (data_byte, end_of_file marks the
// last byte of a file). result channel: one transfer per file carrying status
// (0 ok, 1 bad or unrecognized) and the 31-bit width and height, zero when bad.
// jpeg files (ff d8) are walked marker by marker up to the first frame header;
// everything else is checked as a png header with ihdr.
//
// throughput: one byte per cycle while no result is held stalled, set by the
// combinational state update that sits between the feed register and the result register.
// the byte that decides a result is held in the feed register, and its result
// is then registered in the result register. an answer found early stands; the
// remaining bytes of that file are consumed with no further result.
//
// reset (rst, synchronous): both registers empty, probe at start of file.
// when the result receiver stalls while a result is held, the byte in the feed register waits and
// feed_stall rises, so no byte is lost and no result is overwritten.
module image_header_dimension_probe_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              feed_valid,
  output logic              feed_stall,
  input  ihdp_pkg::feed_t   feed,
  output logic              result_valid,
  input  logic              result_stall,
  output ihdp_pkg::result_t result
);
  import ihdp_pkg::*;

  // feed register
  feed_t        feed_q;
  logic         feed_full;

  // probe state per file
  probe_state_t state;
  probe_state_t state_next;

  logic         emit;
  result_t      res_next;
  logic         advance;

  // the held byte moves on once the result register can take an answer
  assign advance    = feed_full && (!result_valid || !result_stall);
  assign feed_stall = feed_full && !advance;

  ihdp_step u_step (
    .cur  (state),
    .item (feed_q),
    .nxt  (state_next),
    .emit (emit),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_full <= 1'b0;
    end else if (feed_valid && !feed_stall) begin
      feed_full <= 1'b1;
    end else if (advance) begin
      feed_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && !feed_stall) begin
      feed_q <= feed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= res_next;
    end
  end

endmodule

FILE: test/tb_image_header_dimension_probe_core.sv
module tb_image_header_dimension_probe_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ihdp_pkg::*;

  localparam int BYTES_WANTED = 550;
  localparam int FILES_WANTED = 20;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  // ways a generated jpeg file can go wrong
  typedef enum {
    JF_NONE,
    JF_SYNC,
    JF_STOP,
    JF_SHORT_LEN,
    JF_SHORT_FRAME,
    JF_ZERO,
    JF_CUT
  } jpeg_fault_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    feed_valid = 1'b0;
  logic    feed_stall;
  feed_t   feed = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // stimulus and expectations
  feed_t      pending_bytes[$];
  logic [7:0] file_bytes[$];
  result_t    expected_dims[$];
  int         files_queued = 0;
  int         bytes_fed = 0;
  int         fail_count = 0;
  int         idle_cycles = 0;

  // idle control for both sides
  int send_wait = 0;
  int send_calm = 0;
  int take_wait = 0;
  int take_calm = 0;

  // our own copy of the probe state
  phase_t      sn_phase;
  logic [4:0]  sn_pos;
  logic [7:0]  sn_marker;
  logic [15:0] sn_seg;
  logic [31:0] sn_w;
  logic [31:0] sn_h;
  logic        sn_answered;
  logic        sn_sig_ok;

  always #5 clk = ~clk;

  image_header_dimension_probe_core uut (
    .clk          (clk),
    .rst          (rst),
    .feed_valid   (feed_valid),
    .feed_stall   (feed_stall),
    .feed         (feed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // marker classes of the jpeg walk
  function automatic logic frame_code(input logic [7:0] c);
    return ((c & 8'hF0) == MK_SOF0) && c != MK_DHT && c != MK_JPG && c != MK_DAC;
  endfunction

  function automatic logic no_length(input logic [7:0] c);
    return c == MK_SOI || c == MK_TEM || (c >= MK_RST0 && c <= MK_RST7);
  endfunction

  task automatic restart_file();
    sn_phase    = PH_START;
    sn_pos      = '0;
    sn_marker   = '0;
    sn_seg      = '0;
    sn_w        = '0;
    sn_h        = '0;
    sn_answered = 1'b0;
    sn_sig_ok   = 1'b1;
  endtask

  // one answer per file, dimensions zeroed when bad
  task automatic give_answer(input logic ok, input logic [31:0] w, input logic [31:0] h);
    result_t r;
    sn_answered = 1'b1;
    r.status = !ok;
    r.width  = ok ? w[30:0] : '0;
    r.height = ok ? h[30:0] : '0;
    expected_dims.push_back(r);
  endtask

  // advance the probe by one accepted byte
  task automatic sniff_byte(input feed_t f);
    logic [7:0] b;
    b = f.data_byte;
    if (!sn_answered) begin
      case (sn_phase)
        PH_START: begin
          if (sn_pos == 5'd0) begin
            sn_marker = b;
            sn_sig_ok = (b == PNG_SIG0);
            sn_pos    = 5'd1;
          end else if (sn_marker == MK_FILL && b == MK_SOI) begin
            sn_phase = PH_JFF;
          end else begin
            sn_sig_ok = sn_sig_ok && (b == CH_P);
            sn_pos    = 5'd2;
            sn_phase  = PH_PNG;
          end
        end
        PH_PNG: begin
          case (sn_pos)
            5'd2:  sn_sig_ok = sn_sig_ok && (b == CH_N);
            5'd3:  sn_sig_ok = sn_sig_ok && (b == CH_G);
            5'd12: sn_sig_ok = sn_sig_ok && (b == CH_I);
            5'd13: sn_sig_ok = sn_sig_ok && (b == CH_H);
            5'd14: sn_sig_ok = sn_sig_ok && (b == CH_D);
            5'd15: sn_sig_ok = sn_sig_ok && (b == CH_R);
            5'd16, 5'd17, 5'd18, 5'd19: sn_w = {sn_w[23:0], b};
            5'd20, 5'd21, 5'd22, 5'd23: sn_h = {sn_h[23:0], b};
            default: ;
          endcase
          if (sn_pos >= PNG_LAST_POS)
            give_answer(sn_sig_ok && sn_w != 0 && !sn_w[31] && sn_h != 0 && !sn_h[31],
                        sn_w, sn_h);
          else
            sn_pos = sn_pos + 5'd1;
        end
        PH_JFF: begin
          if (b != MK_FILL) give_answer(1'b0, '0, '0);
          else sn_phase = PH_JCODE;
        end
        PH_JCODE: begin
          if (b == MK_FILL) begin
            // fill byte, the code is still to come
          end else if (no_length(b)) begin
            sn_phase = PH_JFF;
          end else if (b == MK_EOI || b == MK_SOS) begin
            give_answer(1'b0, '0, '0);
          end else begin
            sn_marker = b;
            sn_phase  = PH_LENHI;
          end
        end
        PH_LENHI: begin
          sn_seg   = {b, 8'h00};
          sn_phase = PH_LENLO;
        end
        PH_LENLO: begin
          sn_seg = sn_seg | {8'h00, b};
          if (sn_seg < 16'd2) begin
            give_answer(1'b0, '0, '0);
          end else if (frame_code(sn_marker)) begin
            if (sn_seg < 16'd7) begin
              give_answer(1'b0, '0, '0);
            end else begin
              sn_pos   = '0;
              sn_phase = PH_SOF;
            end
          end else begin
            sn_seg   = sn_seg - 16'd2;
            sn_phase = (sn_seg == 0) ? PH_JFF : PH_SKIP;
          end
        end
        PH_SKIP: begin
          sn_seg = sn_seg - 16'd1;
          if (sn_seg == 0) sn_phase = PH_JFF;
        end
        PH_SOF: begin
          // precision, then height and width, 16 bits each
          if (sn_pos == 5'd1 || sn_pos == 5'd2) sn_h = {16'h0, sn_h[7:0], b};
          else if (sn_pos >= 5'd3) sn_w = {16'h0, sn_w[7:0], b};
          if (sn_pos >= 5'd4) give_answer(sn_w != 0 && sn_h != 0, sn_w, sn_h);
          else sn_pos = sn_pos + 5'd1;
        end
      endcase
    end
    if (f.end_of_file) begin
      // a file that ends unanswered is bad
      if (!sn_answered) give_answer(1'b0, '0, '0);
      restart_file();
    end
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_dim16();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h0001;
      1: v = 16'hFFFF;
      2: v = 16'($urandom_range(1, 2000));
      default: v = 16'($urandom);
    endcase
    if (v == 0) v = 16'h0001;
    return v;
  endfunction

  function automatic logic [31:0] pick_dim32(input bit broken);
    logic [31:0] v;
    v = $urandom;
    if (broken) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = 32'h8000_0000;
        2: v = 32'hFFFF_FFFF;
        default: v[31] = 1'b1;
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0: v = 32'd1;
        1: v = 32'h7FFF_FFFF;
        2: v = $urandom_range(1, 4096);
        default: v[31] = 1'b0;
      endcase
      if (v == 0) v = 32'd1;
    end
    return v;
  endfunction

  function automatic logic [7:0] frame_pick();
    logic [7:0] c;
    do c = MK_SOF0 + 8'($urandom_range(0, MK_SOFF - MK_SOF0)); while (!frame_code(c));
    return c;
  endfunction

  // a code that carries a length and is skipped
  function automatic logic [7:0] skip_pick();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = MK_DHT;
      1: c = MK_JPG;
      2: c = MK_DAC;
      default: begin
        do c = rnd_byte();
        while (c == MK_FILL || frame_code(c) || no_length(c) || c == MK_EOI || c == MK_SOS);
      end
    endcase
    return c;
  endfunction

  // queue the collected bytes as one file, optionally cut short
  task automatic ship_file(input int keep);
    feed_t f;
    int    n;
    n = (keep > 0 && keep < file_bytes.size()) ? keep : file_bytes.size();
    for (int i = 0; i < n; i++) begin
      f.data_byte   = file_bytes[i];
      f.end_of_file = (i == n - 1);
      pending_bytes.push_back(f);
    end
    file_bytes.delete();
    files_queued++;
  endtask

  task automatic open_marker();
    file_bytes.push_back(MK_FILL);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) file_bytes.push_back(MK_FILL);
  endtask

  task automatic add_segment();
    logic [15:0] len;
    open_marker();
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 2))
        0: file_bytes.push_back(MK_SOI);
        1: file_bytes.push_back(MK_TEM);
        default: file_bytes.push_back(MK_RST0 + 8'($urandom_range(0, MK_RST7 - MK_RST0)));
      endcase
    end else begin
      file_bytes.push_back(skip_pick());
      // now and then a segment whose length needs the high byte
      len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 270))
                                         : 16'($urandom_range(2, 8));
      file_bytes.push_back(len[15:8]);
      file_bytes.push_back(len[7:0]);
      repeat (len - 2) file_bytes.push_back(rnd_byte());
    end
  endtask

  task automatic build_jpeg();
    jpeg_fault_t fault;
    int          nseg;
    int          keep;
    logic [15:0] len;
    logic [15:0] hh;
    logic [15:0] ww;
    fault = ($urandom_range(0, 1) == 0) ? JF_NONE
                                        : jpeg_fault_t'($urandom_range(JF_SYNC, JF_CUT));
    keep  = 0;
    file_bytes.push_back(MK_FILL);
    file_bytes.push_back(MK_SOI);
    nseg = $urandom_range(0, 3);
    repeat (nseg) add_segment();
    case (fault)
      JF_SYNC: file_bytes.push_back(8'($urandom_range(0, MK_FILL - 1)));
      JF_STOP: begin
        open_marker();
        file_bytes.push_back(($urandom_range(0, 1) == 0) ? MK_EOI : MK_SOS);
      end
      JF_SHORT_LEN: begin
        open_marker();
        file_bytes.push_back(($urandom_range(0, 1) == 0) ? frame_pick() : skip_pick());
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'($urandom_range(0, 1)));
      end
      JF_SHORT_FRAME: begin
        open_marker();
        file_bytes.push_back(frame_pick());
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'($urandom_range(2, 6)));
      end
      default: begin
        hh = pick_dim16();
        ww = pick_dim16();
        if (fault == JF_ZERO) begin
          case ($urandom_range(0, 2))
            0: hh = '0;
            1: ww = '0;
            default: begin
              hh = '0;
              ww = '0;
            end
          endcase
        end
        open_marker();
        file_bytes.push_back(frame_pick());
        len = ($urandom_range(0, 4) == 0) ? {8'($urandom_range(1, 255)), rnd_byte()}
                                          : 16'($urandom_range(7, 17));
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
        file_bytes.push_back(rnd_byte());
        file_bytes.push_back(hh[15:8]);
        file_bytes.push_back(hh[7:0]);
        file_bytes.push_back(ww[15:8]);
        file_bytes.push_back(ww[7:0]);
        if (fault == JF_CUT) keep = $urandom_range(1, file_bytes.size() - 1);
      end
    endcase
    repeat ($urandom_range(0, 3)) file_bytes.push_back(rnd_byte());
    ship_file(keep);
  endtask

  task automatic build_png();
    logic [31:0] w;
    logic [31:0] h;
    int          keep;
    int          spot;
    w = pick_dim32($urandom_range(0, 5) == 0);
    h = pick_dim32($urandom_range(0, 5) == 0);
    file_bytes = '{PNG_SIG0, CH_P, CH_N, CH_G, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
                   8'h00, 8'h00, 8'h00, 8'h0D, CH_I, CH_H, CH_D, CH_R};
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(h[i*8 +: 8]);
    repeat ($urandom_range(0, 4)) file_bytes.push_back(rnd_byte());
    keep = 0;
    case ($urandom_range(0, 9))
      0: begin
        // break one byte of the signature or chunk type
        spot = $urandom_range(0, 7);
        if (spot > 3) spot += 8;
        file_bytes[spot] ^= 8'($urandom_range(1, 255));
      end
      1: file_bytes[$urandom_range(4, 11)] = rnd_byte();
      2: keep = $urandom_range(1, PNG_LAST_POS);
      default: ;
    endcase
    ship_file(keep);
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 12)) file_bytes.push_back(rnd_byte());
    if ($urandom_range(0, 2) == 0) file_bytes[0] = PNG_SIG0;
    ship_file(0);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_dims.size() == 0) begin
      $error("unexpected result: status %0d width %0d height %0d",
             got.status, got.width, got.height);
      fail_count++;
    end else begin
      want = expected_dims.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.width !== want.width) begin
        $error("width: expected %0d, got %0d", want.width, got.width);
        fail_count++;
      end
      if (got.height !== want.height) begin
        $error("height: expected %0d, got %0d", want.height, got.height);
        fail_count++;
      end
    end
  endtask

  // feed driver: presents the next byte once the slot is free and its gap has run out
  always @(posedge clk) begin
    if (rst) begin
      feed_valid <= 1'b0;
      send_wait = 0;
      restart_file();
    end else begin
      if (feed_valid && !feed_stall) begin
        sniff_byte(feed);
        bytes_fed++;
      end
      if (!feed_valid || !feed_stall) begin
        if (send_wait != 0) begin
          send_wait--;
          feed_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          feed <= pending_bytes.pop_front();
          feed_valid <= 1'b1;
          // calm stretches send back to back
          if (send_calm != 0) begin
            send_calm--;
            send_wait = 0;
          end else begin
            send_wait = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(10, 60);
          end
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: holds off each result for its drawn wait, then checks the transfer
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      take_wait = 0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
        if (take_calm != 0) begin
          take_calm--;
          take_wait = 0;
        end else begin
          take_wait = $urandom_range(0, 19);
          if ($urandom_range(0, 7) == 0) take_calm = $urandom_range(4, 20);
        end
      end else if (result_valid && take_wait != 0) begin
        take_wait--;
      end
      result_stall <= (take_wait != 0);
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (rst || (feed_valid && !feed_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int items_total;
    int pick;

    // directed: tiny files and the early failure cases
    file_bytes = '{8'h00};
    ship_file(0);
    // jpeg signature and nothing else
    file_bytes = '{MK_FILL, MK_SOI};
    ship_file(0);
    // lost sync answers at once, the rest of the file is ignored
    file_bytes = '{MK_FILL, MK_SOI, 8'h12, MK_FILL};
    ship_file(0);
    // end of image where a frame header was wanted
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_EOI};
    ship_file(0);
    // fill byte then start of scan
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_SOS};
    ship_file(0);
    // length below two, decided on the last byte of the file
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_DHT, 8'h00, 8'h01};
    ship_file(0);
    // frame header too short to hold the dimensions
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF0, 8'h00, 8'h06};
    ship_file(0);

    // random files, well formed or broken, with random content
    while (pending_bytes.size() < BYTES_WANTED || files_queued < FILES_WANTED) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) build_jpeg();
      else if (pick < 17) build_png();
      else build_noise();
    end
    items_total = pending_bytes.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (bytes_fed != items_total) @(negedge clk);
    while (expected_dims.size() != 0) @(negedge clk);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: image_header_dimension_probe_core.f
rtl/ihdp_pkg.sv
rtl/ihdp_step.sv
rtl/image_header_dimension_probe_core.sv
test/tb_image_header_dimension_probe_core.sv
